[rtl/core/assert_macros.svh]
// assertion macros shared by the scheduler rtl
// each macro expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pts_pkg.sv]
// types, constants and codes for the preemptive priority task scheduler
// no dependencies; used by pts_queues and the scheduler
package pts_pkg;

  // field widths
  localparam int TAG_W   = 8;
  localparam int SVC_W   = 4;
  localparam int PRIO_W  = 2;
  localparam int EVT_W   = 3;

  // queue and stack geometry
  localparam int NUM_Q             = 3;
  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int STACK_DEPTH       = 2;
  localparam int STK_IW            = $clog2(STACK_DEPTH);
  localparam int LVL_W             = $clog2(STACK_DEPTH + 1);

  // priority codes
  localparam logic [PRIO_W-1:0] PRIO_LOW = 2'd2;
  localparam logic [PRIO_W-1:0] NO_QUEUE = 2'd3;

  // event codes
  localparam logic [EVT_W-1:0] EV_IDLE    = 3'd0;
  localparam logic [EVT_W-1:0] EV_CONT    = 3'd1;
  localparam logic [EVT_W-1:0] EV_START   = 3'd2;
  localparam logic [EVT_W-1:0] EV_RESUME  = 3'd3;
  localparam logic [EVT_W-1:0] EV_PREEMPT = 3'd4;

  typedef struct packed {
    logic              arrive_valid;
    logic [TAG_W-1:0]  arrive_tag;
    logic [PRIO_W-1:0] arrive_priority;
    logic [SVC_W-1:0]  arrive_service;
  } in_beat_t;

  typedef struct packed {
    logic [EVT_W-1:0]  event_res;
    logic              busy_res;
    logic [TAG_W-1:0]  run_tag;
    logic [PRIO_W-1:0] run_priority;
    logic [SVC_W-1:0]  run_remaining;
    logic              finished;
    logic              dropped;
  } out_beat_t;

  // one queued task
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SVC_W-1:0] svc;
  } entry_t;

  // one preempted task
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SVC_W-1:0]  svc;
    logic [PRIO_W-1:0] prio;
  } stk_entry_t;

  // scheduler to queue unit
  typedef struct packed {
    logic              enq;
    logic [PRIO_W-1:0] enq_sel;
    logic              pop;
    logic [PRIO_W-1:0] pop_sel;
  } q_cmd_t;

  // queue unit to scheduler
  typedef struct packed {
    logic [NUM_Q-1:0] nonempty;
    logic [NUM_Q-1:0] full;
  } q_stat_t;

endpackage

[rtl/core/pts_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module pts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/pts_queues.sv]
// three priority fifos sharing one ram, with head/count per fifo
// depends on pts_pkg, pts_ram and assert_macros.svh
`include "assert_macros.svh"

module pts_queues #(
  parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pts_pkg::q_cmd_t   cmd,
  input  pts_pkg::entry_t   enq_entry,
  output pts_pkg::q_stat_t  stat,
  output pts_pkg::entry_t   head
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = IW + 2;
  localparam int EW = $bits(pts_pkg::entry_t);
  localparam int MD = pts_pkg::NUM_Q * QUEUE_DEPTH;
  localparam int AW = $clog2(MD);

  logic [CW-1:0]   count [pts_pkg::NUM_Q];
  logic [IW-1:0]   hd    [pts_pkg::NUM_Q];
  logic [IW-1:0]   tail  [pts_pkg::NUM_Q];
  logic [pts_pkg::NUM_Q-1:0] fwd_hit;

  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [EW-1:0]   rdata;
  logic            fwd;
  pts_pkg::entry_t fwd_data;

  logic            count_ok;
  logic            pop_ok;
  logic            enq_ok;

  for (genvar q = 0; q < pts_pkg::NUM_Q; q++) begin : g_q
    logic          enq_here;
    logic          pop_here;
    logic [SW-1:0] sum;
    logic [SW-1:0] slot;

    assign enq_here = cmd.enq && (cmd.enq_sel == pts_pkg::PRIO_W'(q));
    assign pop_here = cmd.pop && (cmd.pop_sel == pts_pkg::PRIO_W'(q));

    // tail slot = head + count, wrapped once
    assign sum     = SW'(hd[q]) + SW'(count[q]);
    assign slot    = (sum >= SW'(QUEUE_DEPTH)) ? sum - SW'(QUEUE_DEPTH) : sum;
    assign tail[q] = slot[IW-1:0];

    // same-cycle write and read of an empty fifo's head
    assign fwd_hit[q] = enq_here && pop_here && (count[q] == '0);

    assign stat.nonempty[q] = (count[q] != '0);
    assign stat.full[q]     = (count[q] >= CW'(QUEUE_DEPTH));

    // head pointer and fill count
    always_ff @(posedge clk) begin
      if (rst) begin
        hd[q]    <= '0;
        count[q] <= '0;
      end else begin
        if (pop_here) begin
          hd[q] <= (hd[q] == IW'(QUEUE_DEPTH - 1)) ? '0 : hd[q] + 1'b1;
        end
        if (enq_here && !pop_here) begin
          count[q] <= count[q] + 1'b1;
        end else if (pop_here && !enq_here) begin
          count[q] <= count[q] - 1'b1;
        end
      end
    end
  end

  // ram addresses: each fifo owns one block of QUEUE_DEPTH entries
  always_comb begin
    wr_addr = '0;
    rd_addr = '0;
    for (int q = 0; q < pts_pkg::NUM_Q; q++) begin
      if (cmd.enq_sel == pts_pkg::PRIO_W'(q)) begin
        wr_addr = AW'(q * QUEUE_DEPTH) + AW'(tail[q]);
      end
      if (cmd.pop_sel == pts_pkg::PRIO_W'(q)) begin
        rd_addr = AW'(q * QUEUE_DEPTH) + AW'(hd[q]);
      end
    end
  end

  pts_ram #(
    .WIDTH (EW),
    .DEPTH (MD)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.enq),
    .wr_addr (wr_addr),
    .wr_data (enq_entry),
    .rd_en   (cmd.pop),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // remember whether the ram is bypassed
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      fwd      <= |fwd_hit;
      fwd_data <= enq_entry;
    end
  end

  // head data, valid from the cycle after the pop
  assign head = fwd ? fwd_data : pts_pkg::entry_t'(rdata);

  // assertion terms
  assign count_ok = (count[0] <= CW'(QUEUE_DEPTH)) && (count[1] <= CW'(QUEUE_DEPTH)) &&
                    (count[2] <= CW'(QUEUE_DEPTH));
  assign pop_ok   = (cmd.pop_sel <= pts_pkg::PRIO_LOW) &&
                    (stat.nonempty[cmd.pop_sel] || (cmd.enq && cmd.enq_sel == cmd.pop_sel));
  assign enq_ok   = (cmd.enq_sel <= pts_pkg::PRIO_LOW) && !stat.full[cmd.enq_sel];

  `ASSERT_ALWAYS(a_count_bound, count_ok, "fifo count beyond depth")
  `ASSERT_IMPLY(a_pop_nonempty, cmd.pop, pop_ok, "pop from empty fifo")
  `ASSERT_IMPLY(a_enq_room, cmd.enq, enq_ok, "enqueue into full fifo")

endmodule

[rtl/core/preemptive_priority_task_scheduler.sv]
// one result per accepted tick; the result is registered when phase B completes with the output register free
// a new tick is not taken until the last one leaves phase B: the queue ram read separates
// the scheduling decision from the popped task's tag and service time
// a full output register holds the block in phase B until drained
// synchronous reset clears fifo counts, stack level and the server;
// fifo ram contents are not cleared
`include "assert_macros.svh"

module preemptive_priority_task_scheduler #(
  parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               task_valid,
  output logic               task_stall,
  input  pts_pkg::in_beat_t  task_beat,
  output logic               res_valid,
  input  logic               res_stall,
  output pts_pkg::out_beat_t res_beat
);

  localparam logic PH_A = 1'b0;
  localparam logic PH_B = 1'b1;

  logic phase;
  logic acc;
  logic done_b;

  // server and stack state
  logic                        run_valid;
  logic [pts_pkg::TAG_W-1:0]   run_tag;
  logic [pts_pkg::SVC_W-1:0]   run_svc;
  logic [pts_pkg::PRIO_W-1:0]  run_prio;
  logic [pts_pkg::LVL_W-1:0]   lvl;
  pts_pkg::stk_entry_t         stk [pts_pkg::STACK_DEPTH];

  // decision held over to phase B
  logic                        pend_pop;
  logic [pts_pkg::EVT_W-1:0]   evt_q;
  logic                        drop_q;

  // queue unit link
  pts_pkg::q_cmd_t  qcmd;
  pts_pkg::q_stat_t qstat;
  pts_pkg::entry_t  qhead;
  pts_pkg::entry_t  enq_entry;

  // decision signals
  logic [pts_pkg::PRIO_W-1:0]  arr_prio;
  logic                        enq_ok;
  logic                        drop;
  logic [pts_pkg::NUM_Q-1:0]   ne;
  logic [pts_pkg::PRIO_W-1:0]  best;
  logic [pts_pkg::LVL_W-1:0]   lvl_dec;
  logic [pts_pkg::STK_IW-1:0]  top_idx;
  pts_pkg::stk_entry_t         stk_top;
  logic [pts_pkg::EVT_W-1:0]   evt;
  logic                        do_pop;
  logic                        do_push;
  logic                        do_resume;
  logic [pts_pkg::LVL_W-1:0]   lvl_next;
  logic                        rv_next;
  logic [pts_pkg::PRIO_W-1:0]  rp_next;

  // phase B signals
  logic [pts_pkg::TAG_W-1:0]   cur_tag;
  logic [pts_pkg::SVC_W-1:0]   cur_svc;
  logic [pts_pkg::SVC_W-1:0]   svc_dec;
  logic                        fin;

  assign task_stall = (phase == PH_B);
  assign acc        = task_valid && !task_stall;
  assign done_b     = (phase == PH_B) && (!res_valid || !res_stall);

  // arrival, best fifo and scheduling decision
  always_comb begin
    arr_prio = (task_beat.arrive_priority > pts_pkg::PRIO_LOW) ?
               pts_pkg::PRIO_LOW : task_beat.arrive_priority;
    enq_ok   = task_beat.arrive_valid && !qstat.full[arr_prio];
    drop     = task_beat.arrive_valid && qstat.full[arr_prio];
    ne       = qstat.nonempty;
    if (enq_ok) begin
      ne[arr_prio] = 1'b1;
    end

    priority if (ne[0]) begin
      best = 2'd0;
    end else if (ne[1]) begin
      best = 2'd1;
    end else if (ne[2]) begin
      best = 2'd2;
    end else begin
      best = pts_pkg::NO_QUEUE;
    end

    lvl_dec   = lvl - 1'b1;
    top_idx   = lvl_dec[pts_pkg::STK_IW-1:0];
    stk_top   = stk[top_idx];

    evt       = pts_pkg::EV_IDLE;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    do_resume = 1'b0;
    lvl_next  = lvl;
    rv_next   = run_valid;
    rp_next   = run_prio;

    if (!run_valid) begin
      if (lvl != '0 && lvl <= pts_pkg::LVL_W'(pts_pkg::STACK_DEPTH) &&
          stk_top.prio <= best) begin
        evt       = pts_pkg::EV_RESUME;
        do_resume = 1'b1;
        lvl_next  = lvl_dec;
        rv_next   = 1'b1;
        rp_next   = stk_top.prio;
      end else if (best != pts_pkg::NO_QUEUE) begin
        evt     = pts_pkg::EV_START;
        do_pop  = 1'b1;
        rv_next = 1'b1;
        rp_next = best;
      end
    end else if (best < run_prio) begin
      evt     = pts_pkg::EV_PREEMPT;
      do_pop  = 1'b1;
      rp_next = best;
      if (lvl < pts_pkg::LVL_W'(pts_pkg::STACK_DEPTH)) begin
        do_push  = 1'b1;
        lvl_next = lvl + 1'b1;
      end
    end else begin
      evt = pts_pkg::EV_CONT;
    end
  end

  // queue commands, only on the accept cycle
  always_comb begin
    qcmd.enq      = acc && enq_ok;
    qcmd.enq_sel  = arr_prio;
    qcmd.pop      = acc && do_pop;
    qcmd.pop_sel  = best;
    enq_entry.tag = task_beat.arrive_tag;
    enq_entry.svc = task_beat.arrive_service;
  end

  pts_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk       (clk),
    .rst       (rst),
    .cmd       (qcmd),
    .enq_entry (enq_entry),
    .stat      (qstat),
    .head      (qhead)
  );

  // served task and its decrement
  always_comb begin
    cur_tag = pend_pop ? qhead.tag : run_tag;
    cur_svc = pend_pop ? qhead.svc : run_svc;
    svc_dec = (cur_svc != '0) ? cur_svc - 1'b1 : '0;
    fin     = run_valid && (svc_dec == '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_A;
      res_valid <= 1'b0;
      run_valid <= 1'b0;
      lvl       <= '0;
      pend_pop  <= 1'b0;
    end else begin
      if (acc) begin
        phase     <= PH_B;
        run_valid <= rv_next;
        lvl       <= lvl_next;
        pend_pop  <= do_pop;
      end
      if (done_b) begin
        phase     <= PH_A;
        run_valid <= run_valid && !fin;
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload: running task, stack entries and result beat
  always_ff @(posedge clk) begin
    if (acc) begin
      evt_q    <= evt;
      drop_q   <= drop;
      run_prio <= rp_next;
      if (do_resume) begin
        run_tag <= stk_top.tag;
        run_svc <= stk_top.svc;
      end
      if (do_push) begin
        stk[lvl[pts_pkg::STK_IW-1:0]] <= '{tag: run_tag, svc: run_svc, prio: run_prio};
      end
    end
    if (done_b) begin
      run_tag                <= cur_tag;
      run_svc                <= svc_dec;
      res_beat.event_res     <= evt_q;
      res_beat.busy_res      <= run_valid;
      res_beat.run_tag       <= run_valid ? cur_tag : '0;
      res_beat.run_priority  <= run_valid ? run_prio : '0;
      res_beat.run_remaining <= run_valid ? svc_dec : '0;
      res_beat.finished      <= fin;
      res_beat.dropped       <= drop_q;
    end
  end

  `ASSERT_ALWAYS(a_stack_bound, lvl <= pts_pkg::LVL_W'(pts_pkg::STACK_DEPTH), "stack overflow")
  `ASSERT_IMPLY(a_preempt_room, acc && evt == pts_pkg::EV_PREEMPT, do_push, "stack full on preempt")
  `ASSERT_IMPLY(a_rise_after_b, $rose(res_valid), $past(phase) == PH_B, "early result")
  `ASSERT_NEXT(a_pop_fills_server, acc && do_pop, run_valid && pend_pop, "popped task not served")

endmodule
